// ----- sv/ccd_pkg.sv -----
// Shared types, codes and lookup functions for the cartridge chunk deframer.
`timescale 1ns / 1ps
package ccd_pkg;

    localparam logic [3:0] REGION_TILES    = 4'd0;
    localparam logic [3:0] REGION_SPRITES  = 4'd1;
    localparam logic [3:0] REGION_MAP      = 4'd2;
    localparam logic [3:0] REGION_SFX      = 4'd3;
    localparam logic [3:0] REGION_WAVES    = 4'd4;
    localparam logic [3:0] REGION_PATTERNS = 4'd5;
    localparam logic [3:0] REGION_TRACKS   = 4'd6;
    localparam logic [3:0] REGION_FLAGS    = 4'd7;
    localparam logic [3:0] REGION_PALETTE  = 4'd8;
    localparam logic [3:0] REGION_CODE     = 4'd9;
    localparam logic [3:0] REGION_NONE     = 4'd15;

    localparam logic [4:0] KIND_TILES      = 5'd1;
    localparam logic [4:0] KIND_SPRITES    = 5'd2;
    localparam logic [4:0] KIND_MAP        = 5'd4;
    localparam logic [4:0] KIND_CODE       = 5'd5;
    localparam logic [4:0] KIND_FLAGS      = 5'd6;
    localparam logic [4:0] KIND_SFX        = 5'd9;
    localparam logic [4:0] KIND_WAVES      = 5'd10;
    localparam logic [4:0] KIND_PALETTE    = 5'd12;
    localparam logic [4:0] KIND_TRACKS     = 5'd14;
    localparam logic [4:0] KIND_PATTERNS   = 5'd15;
    localparam logic [4:0] KIND_CODE_ZIP   = 5'd16;
    localparam logic [4:0] KIND_DEFAULT    = 5'd17;
    localparam logic [4:0] KIND_BINARY     = 5'd19;
    localparam logic [4:0] KIND_LANG       = 5'd20;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_PNG        = 3'd1;
    localparam logic [2:0] ST_PAST_END   = 3'd2;
    localparam logic [2:0] ST_COMPRESSED = 3'd3;
    localparam logic [2:0] ST_LANGUAGE   = 3'd4;
    localparam logic [2:0] ST_NO_CODE    = 3'd5;

    localparam logic [16:0] SIZE_FULL = 17'h10000;
    localparam logic [7:0]  LANG_RESET = 8'd10;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_file;
    } t_item;

    typedef struct packed {
        logic        write_valid;
        logic [3:0]  region;
        logic [2:0]  bank;
        logic [15:0] offset;
        logic [7:0]  data_out;
        logic        load_defaults;
        logic [2:0]  status;
        logic        done_res;
    } t_result;

    function automatic logic [3:0] region_of_kind(input logic [4:0] kind);
        logic [3:0] r;
        begin
            case (kind)
                KIND_TILES:    r = REGION_TILES;
                KIND_SPRITES:  r = REGION_SPRITES;
                KIND_MAP:      r = REGION_MAP;
                KIND_CODE:     r = REGION_CODE;
                KIND_FLAGS:    r = REGION_FLAGS;
                KIND_SFX:      r = REGION_SFX;
                KIND_WAVES:    r = REGION_WAVES;
                KIND_PALETTE:  r = REGION_PALETTE;
                KIND_TRACKS:   r = REGION_TRACKS;
                KIND_PATTERNS: r = REGION_PATTERNS;
                default:       r = REGION_NONE;
            endcase
            return r;
        end
    endfunction

    function automatic logic [16:0] region_limit(input logic [3:0] region);
        logic [16:0] lim;
        begin
            case (region)
                REGION_TILES:    lim = 17'd8192;
                REGION_SPRITES:  lim = 17'd8192;
                REGION_MAP:      lim = 17'(240 * 136);
                REGION_SFX:      lim = 17'(64 * 66);
                REGION_WAVES:    lim = 17'd256;
                REGION_PATTERNS: lim = 17'(60 * 192);
                REGION_TRACKS:   lim = 17'(8 * 51);
                REGION_FLAGS:    lim = 17'd512;
                REGION_PALETTE:  lim = 17'd96;
                default:         lim = SIZE_FULL;
            endcase
            return lim;
        end
    endfunction

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        begin
            case (idx)
                2'd0:    m = 8'h89;
                2'd1:    m = 8'h50;
                2'd2:    m = 8'h4E;
                default: m = 8'h47;
            endcase
            return m;
        end
    endfunction

endpackage

// ----- sv/cart_chunk_deframer.sv -----
// Cartridge chunk deframer: byte stream in, region write words out.
// Pipeline: two register stages, the input register and the result register.
// Throughput: one word per cycle when not stalled; parse is one header/payload pass.
// Back-pressure on the result side stalls the parse and then the input side.
// Reset (synchronous, active low) clears the parser state and sets the accepted language to 10.
`timescale 1ns / 1ps
module cart_chunk_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic        s_axis_tlast,   // end_of_file
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [2:0] bank, [18:3] offset, [26:19] data_out,
                                        // [27] load_defaults, [30:28] status, [31] zero
    output logic [4:0]  m_axis_tuser,   // [0] write_valid, [4:1] region
    output logic        m_axis_tlast    // done_res
);
    import ccd_pkg::*;

    t_item   in_item;
    t_item   held_item;
    t_result core_res;
    t_result out_res;
    logic    held_valid;
    logic    out_free;
    logic    step;

    assign in_item.byte_in     = s_axis_tdata;
    assign in_item.end_of_file = s_axis_tlast;
    assign step                = held_valid && out_free;

    ccd_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .i_take  (step),
        .o_item  (held_item)
    );

    ccd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (step),
        .i_item      (held_item),
        .o_res       (core_res)
    );

    ccd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step),
        .i_res   (core_res),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {1'b0, out_res.status, out_res.load_defaults, out_res.data_out,
                           out_res.offset, out_res.bank};
    assign m_axis_tuser = {out_res.region, out_res.write_valid};
    assign m_axis_tlast = out_res.done_res;

endmodule

// ----- sv/ccd_in_reg.sv -----
// Input register: holds one incoming word until the parser takes it.
`timescale 1ns / 1ps
module ccd_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ccd_pkg::t_item i_item,
    output logic          o_valid,
    input  logic          i_take,
    output ccd_pkg::t_item o_item
);
    import ccd_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- sv/ccd_core.sv -----
// Parser state and per-word header, payload and error logic.
`timescale 1ns / 1ps
module ccd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata,
    input  logic             i_step,
    input  ccd_pkg::t_item   i_item,
    output ccd_pkg::t_result o_res
);
    import ccd_pkg::*;

    logic [7:0]  r_accept_lang;
    logic [1:0]  r_hidx,   n_hidx;
    logic        r_in_pay, n_in_pay;
    logic [4:0]  r_kind,   n_kind;
    logic [2:0]  r_bank,   n_bank;
    logic [7:0]  r_low,    n_low;
    logic [16:0] r_left,   n_left;
    logic [15:0] r_off,    n_off;
    logic        r_first,  n_first;
    logic        r_magic,  n_magic;
    logic [7:0]  r_lang,   n_lang;
    logic        r_code,   n_code;
    logic [2:0]  r_err,    n_err;

    always_comb begin
        logic [7:0] b;
        logic [3:0] r;
        logic [2:0] err;
        logic       mm;
        b        = i_item.byte_in;
        r        = region_of_kind(r_kind);
        err      = r_err;
        mm       = r_magic;
        n_hidx   = r_hidx;
        n_in_pay = r_in_pay;
        n_kind   = r_kind;
        n_bank   = r_bank;
        n_low    = r_low;
        n_left   = r_left;
        n_off    = r_off;
        n_first  = r_first;
        n_magic  = r_magic;
        n_lang   = r_lang;
        n_code   = r_code;
        o_res    = '0;

        if (r_in_pay) begin
            if (r_kind == KIND_LANG && r_off == 16'd0) begin
                n_lang = b;
            end
            if (r != REGION_NONE && (r == REGION_CODE || r_bank == 3'd0) &&
                {1'b0, r_off} < region_limit(r) && r_err == ST_OK) begin
                o_res.write_valid = 1'b1;
                o_res.region      = r;
                o_res.bank        = r_bank;
                o_res.offset      = r_off;
                o_res.data_out    = b;
            end
            n_off  = r_off + 16'd1;
            n_left = r_left - 17'd1;
            if (n_left == 17'd0) begin
                n_in_pay = 1'b0;
                n_hidx   = 2'd0;
            end
        end else begin
            if (r_first && b != magic_byte(r_hidx)) begin
                mm = 1'b0;
            end
            n_magic = mm;
            case (r_hidx)
                2'd0: begin
                    n_kind = b[4:0];
                    n_bank = b[7:5];
                    n_hidx = 2'd1;
                end
                2'd1: begin
                    n_low  = b;
                    n_hidx = 2'd2;
                end
                2'd2: begin
                    n_left = {1'b0, b, r_low};
                    if (n_left == 17'd0 && (r_kind == KIND_CODE || r_kind == KIND_BINARY)) begin
                        n_left = SIZE_FULL;
                    end
                    n_hidx = 2'd3;
                end
                default: begin
                    if (r_first && mm && err == ST_OK) begin
                        err = ST_PNG;
                    end
                    n_first = 1'b0;
                    n_magic = 1'b0;
                    n_hidx  = 2'd0;
                    n_off   = 16'd0;
                    if (r_kind == KIND_CODE_ZIP && err == ST_OK) begin
                        err = ST_COMPRESSED;
                    end
                    if (r_kind == KIND_CODE) begin
                        n_code = 1'b1;
                    end
                    if (r_kind == KIND_LANG && r_left == 17'd0) begin
                        n_lang = 8'd0;
                    end
                    if (r_kind == KIND_DEFAULT && r_bank == 3'd0 && err == ST_OK) begin
                        o_res.load_defaults = 1'b1;
                    end
                    n_in_pay = (r_left != 17'd0);
                end
            endcase
        end

        if (i_item.end_of_file) begin
            if (n_in_pay && n_left != 17'd0 && err == ST_OK) begin
                err = ST_PAST_END;
            end
            if (n_lang != 8'd0 && n_lang != r_accept_lang && err == ST_OK) begin
                err = ST_LANGUAGE;
            end
            if (!n_code && err == ST_OK) begin
                err = ST_NO_CODE;
            end
        end

        o_res.status   = err;
        o_res.done_res = i_item.end_of_file;
        n_err          = err;

        if (i_item.end_of_file) begin
            n_hidx   = 2'd0;
            n_in_pay = 1'b0;
            n_kind   = 5'd0;
            n_bank   = 3'd0;
            n_low    = 8'd0;
            n_left   = 17'd0;
            n_off    = 16'd0;
            n_first  = 1'b1;
            n_magic  = 1'b1;
            n_lang   = 8'd0;
            n_code   = 1'b0;
            n_err    = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_lang <= LANG_RESET;
        end else if (i_cfg_we) begin
            r_accept_lang <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hidx   <= 2'd0;
            r_in_pay <= 1'b0;
            r_kind   <= 5'd0;
            r_bank   <= 3'd0;
            r_low    <= 8'd0;
            r_left   <= 17'd0;
            r_off    <= 16'd0;
            r_first  <= 1'b1;
            r_magic  <= 1'b1;
            r_lang   <= 8'd0;
            r_code   <= 1'b0;
            r_err    <= ST_OK;
        end else if (i_step) begin
            r_hidx   <= n_hidx;
            r_in_pay <= n_in_pay;
            r_kind   <= n_kind;
            r_bank   <= n_bank;
            r_low    <= n_low;
            r_left   <= n_left;
            r_off    <= n_off;
            r_first  <= n_first;
            r_magic  <= n_magic;
            r_lang   <= n_lang;
            r_code   <= n_code;
            r_err    <= n_err;
        end
    end

endmodule

// ----- sv/ccd_out_reg.sv -----
// Result register: holds one result word until the downstream side takes it.
`timescale 1ns / 1ps
module ccd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ccd_pkg::t_result i_res,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output ccd_pkg::t_result o_res
);
    import ccd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule
